// ----- src/wllp_pkg.sv -----
// Shared types, codes and helpers for the weighted least-load picker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wllp_pkg;

   // Default sizes handed to the top level's parameters
   localparam int NUM_BACKENDS_DEF = 8;
   localparam int COUNT_WIDTH_DEF  = 16;

   // Fixed field widths
   localparam int IDX_W      = 3;
   localparam int WEIGHT_W   = 8;
   localparam int HANDLED_W  = 32;
   localparam int REPORT_W   = 16;
   localparam int CFG_CNT_W  = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int WEIGHTS_W  = 64;

   // Action codes
   localparam logic [1:0] ACT_PICK    = 2'd0;
   localparam logic [1:0] ACT_REPORT  = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_QUERY   = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NONE  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_UNDER = 2'd3;

   // Register indexes (paddr bit 3 selects the 64-bit register)
   localparam logic CSR_IDX_COUNT   = 1'b0;
   localparam logic CSR_IDX_WEIGHTS = 1'b1;

   typedef struct packed {
      logic [1:0]       action;
      logic [IDX_W-1:0] backend_index;
      logic             pool_ok;
   } wllp_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_W-1:0]     chosen_index;
      logic [REPORT_W-1:0]  in_flight_now;
      logic [HANDLED_W-1:0] handled_now;
   } wllp_rsp_type;

   // Counter bank write control
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } wllp_wr_type;

   // Weight of one backend; zero counts as one
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [WEIGHTS_W-1:0] weights,
                                                     input logic [IDX_W-1:0]     idx);
      logic [WEIGHT_W-1:0] w;
      w = weights[WEIGHT_W*idx +: WEIGHT_W];
      return (w == '0) ? WEIGHT_W'(1) : w;
   endfunction

endpackage

`default_nettype wire

// ----- src/wllp_ratio_cmp.sv -----
// Shared cross-multiply compare unit: load/w < best_load/best_w.
// Depends on wllp_pkg.
`default_nettype none

module wllp_ratio_cmp #(
   parameter int COUNT_WIDTH = wllp_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic [COUNT_WIDTH-1:0]        load,
   input  wire logic [wllp_pkg::WEIGHT_W-1:0] weight,
   input  wire logic [COUNT_WIDTH-1:0]        best_load,
   input  wire logic [wllp_pkg::WEIGHT_W-1:0] lead_weight,
   output logic                               less
);

   localparam int PW = COUNT_WIDTH + wllp_pkg::WEIGHT_W;

   logic [PW-1:0] lhs;
   logic [PW-1:0] rhs;

   assign lhs  = PW'(load) * PW'(lead_weight);
   assign rhs  = PW'(best_load) * PW'(weight);
   assign less = lhs < rhs;

endmodule

`default_nettype wire

// ----- src/wllp_counter_bank.sv -----
// Per-backend in-flight and handled counters, one read and one write port.
// Depends on wllp_pkg.
`default_nettype none

module wllp_counter_bank #(
   parameter int NUM_BACKENDS = wllp_pkg::NUM_BACKENDS_DEF,
   parameter int COUNT_WIDTH  = wllp_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [wllp_pkg::IDX_W-1:0]         rd_addr,
   output logic [COUNT_WIDTH-1:0]                  rd_inflight,
   output logic [wllp_pkg::HANDLED_W-1:0]          rd_handled,
   input  wire wllp_pkg::wllp_wr_type              wr,
   input  wire logic [COUNT_WIDTH-1:0]             wr_inflight,
   input  wire logic [wllp_pkg::HANDLED_W-1:0]     wr_handled
);

   localparam int AW = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;

   logic [COUNT_WIDTH-1:0]         inflight_ff [NUM_BACKENDS];
   logic [wllp_pkg::HANDLED_W-1:0] handled_ff  [NUM_BACKENDS];

   logic rd_ok;
   logic wr_ok;

   assign rd_ok = {1'b0, rd_addr} < (wllp_pkg::IDX_W + 1)'(NUM_BACKENDS);
   assign wr_ok = {1'b0, wr.addr} < (wllp_pkg::IDX_W + 1)'(NUM_BACKENDS);

   assign rd_inflight = rd_ok ? inflight_ff[rd_addr[AW-1:0]] : '0;
   assign rd_handled  = rd_ok ? handled_ff[rd_addr[AW-1:0]]  : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BACKENDS; i++) begin
            inflight_ff[i] <= '0;
            handled_ff[i]  <= '0;
         end
      end else if (wr.en && wr_ok) begin
         inflight_ff[wr.addr[AW-1:0]] <= wr_inflight;
         handled_ff[wr.addr[AW-1:0]]  <= wr_handled;
      end
   end

endmodule

`default_nettype wire

// ----- src/weighted_least_load_picker_core.sv -----
// Top level of the weighted least-load picker: sequencer, config registers,
// result register. Depends on wllp_pkg, wllp_ratio_cmp, wllp_counter_bank.
//
//   channel | ports                        | direction | moves
//   --------+------------------------------+-----------+---------------------------
//   req     | req_valid/req_stall/req_data | in        | one item: action, index, ok
//   rsp     | rsp_valid/rsp_stall/rsp_data | out       | one result item per item
//   csr     | psel/penable/pwrite/paddr/.. | in/out    | backend_count, weights
//
// Steps: a pick goes through accept, one compare per active backend through the
//   single cross-multiply unit, and update; a pick with no backends and every other
//   action goes from accept straight to update. A new item is taken only once the last has left update.
// Reset: synchronous, active high; clears the counters, the registers, the
//   sequencer and the result valid flag.
// Stalls: the finished result sits in an output register, so a new item is
//   taken while it waits; the update step holds until that register is free.
`default_nettype none

module weighted_least_load_picker_core #(
   parameter int NUM_BACKENDS = wllp_pkg::NUM_BACKENDS_DEF,
   parameter int COUNT_WIDTH  = wllp_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // item input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire wllp_pkg::wllp_req_type             req_data,
   // result output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output wllp_pkg::wllp_rsp_type                  rsp_data,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [wllp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [wllp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [wllp_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   localparam int IW  = wllp_pkg::IDX_W;
   localparam int NW  = IW + 1;
   localparam int WW  = wllp_pkg::WEIGHT_W;
   localparam int HW  = wllp_pkg::HANDLED_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // latched item
   logic [1:0]             act_ff, act_in;
   logic                   ok_ff, ok_in;
   logic [IW-1:0]          tgt_ff, tgt_in;     // named backend, or best so far on a pick

   // scan of the pick
   logic [IW-1:0]          scan_ff, scan_in;
   logic                   have_best_ff, have_best_in;
   logic [COUNT_WIDTH-1:0] best_load_ff, best_load_in;
   logic [WW-1:0]          best_w_ff, best_w_in;

   // configuration
   logic [wllp_pkg::CFG_CNT_W-1:0] cfg_count_ff, cfg_count_in;
   logic [wllp_pkg::WEIGHTS_W-1:0] cfg_weights_ff, cfg_weights_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   wllp_pkg::wllp_rsp_type rsp_data_ff, rsp_data_in;

   // datapath
   logic [NW-1:0]          active;
   logic [IW-1:0]          rd_addr;
   logic [COUNT_WIDTH-1:0] cur_if;
   logic [HW-1:0]          cur_hd;
   logic [WW-1:0]          scan_w;
   logic                   less;
   logic                   take;
   logic                   scan_last;
   logic                   req_fire;
   logic                   out_free;
   logic                   exec_fire;
   logic                   in_range;
   logic                   csr_wr;

   logic [COUNT_WIDTH-1:0] new_if;
   logic [HW-1:0]          new_hd;
   logic [1:0]             stat;
   logic                   do_write;
   logic [31:0]            if_wide;
   wllp_pkg::wllp_wr_type  wr;

   // ---------------- register port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_count_in   = cfg_count_ff;
      cfg_weights_in = cfg_weights_ff;
      if (csr_wr) begin
         unique case (paddr[3])
            wllp_pkg::CSR_IDX_COUNT:   cfg_count_in   = pwdata[wllp_pkg::CFG_CNT_W-1:0];
            wllp_pkg::CSR_IDX_WEIGHTS: cfg_weights_in = pwdata;
            default:                   cfg_count_in   = cfg_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         wllp_pkg::CSR_IDX_COUNT:   prdata = wllp_pkg::CSR_DATA_W'(cfg_count_ff);
         wllp_pkg::CSR_IDX_WEIGHTS: prdata = cfg_weights_ff;
         default:                   prdata = '0;
      endcase
   end

   // a count above the backend limit acts as the limit
   assign active = ({1'b0, cfg_count_ff} > (wllp_pkg::CFG_CNT_W + 1)'(NUM_BACKENDS))
                   ? NW'(NUM_BACKENDS) : NW'(cfg_count_ff);

   // ---------------- counters and compare unit ----------------
   assign rd_addr = (state_ff == S_SCAN) ? scan_ff : tgt_ff;

   wllp_counter_bank #(
      .NUM_BACKENDS (NUM_BACKENDS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_bank (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (rd_addr),
      .rd_inflight (cur_if),
      .rd_handled  (cur_hd),
      .wr          (wr),
      .wr_inflight (new_if),
      .wr_handled  (new_hd)
   );

   assign scan_w = wllp_pkg::weight_of(cfg_weights_ff, scan_ff);

   wllp_ratio_cmp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_cmp (
      .load        (cur_if),
      .weight      (scan_w),
      .best_load   (best_load_ff),
      .lead_weight (best_w_ff),
      .less        (less)
   );

   // first backend always seeds the best; later ones need a strictly smaller ratio
   assign take      = !have_best_ff || less;
   assign scan_last = ({1'b0, scan_ff} == (active - NW'(1)));

   // ---------------- handshakes ----------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = (state_ff == S_EXEC) && out_free;
   assign in_range  = {1'b0, tgt_ff} < active;

   // ---------------- update step ----------------
   always_comb begin
      new_if   = cur_if;
      new_hd   = cur_hd;
      stat     = wllp_pkg::STAT_OK;
      do_write = 1'b0;
      priority if (act_ff == wllp_pkg::ACT_PICK && active == '0) begin
         stat = wllp_pkg::STAT_NONE;
      end else if (act_ff != wllp_pkg::ACT_PICK && !in_range) begin
         stat = wllp_pkg::STAT_RANGE;
      end else begin
         do_write = 1'b1;
         unique case (act_ff)
            wllp_pkg::ACT_PICK: begin
               if (cur_if != '1) new_if = cur_if + COUNT_WIDTH'(1);
            end
            wllp_pkg::ACT_REPORT: begin
               if (ok_ff) begin
                  if (cur_hd != '1) new_hd = cur_hd + HW'(1);
               end else if (cur_if == '0) begin
                  stat = wllp_pkg::STAT_UNDER;
               end else begin
                  new_if = cur_if - COUNT_WIDTH'(1);
               end
            end
            wllp_pkg::ACT_RELEASE: begin
               if (cur_if == '0) stat = wllp_pkg::STAT_UNDER;
               else new_if = cur_if - COUNT_WIDTH'(1);
            end
            wllp_pkg::ACT_QUERY: begin
               do_write = 1'b0;
            end
            default: do_write = 1'b0;
         endcase
      end
   end

   assign wr.en   = exec_fire && do_write;
   assign wr.addr = tgt_ff;
   assign if_wide = 32'(new_if);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      ok_in        = ok_ff;
      tgt_in       = tgt_ff;
      scan_in      = scan_ff;
      have_best_in = have_best_ff;
      best_load_in = best_load_ff;
      best_w_in    = best_w_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in       = req_data.action;
               ok_in        = req_data.pool_ok;
               tgt_in       = req_data.backend_index;
               scan_in      = '0;
               have_best_in = 1'b0;
               if (req_data.action == wllp_pkg::ACT_PICK && active != '0) state_in = S_SCAN;
               else state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            if (take) begin
               tgt_in       = scan_ff;
               best_load_in = cur_if;
               best_w_in    = scan_w;
               have_best_in = 1'b1;
            end
            scan_in = scan_ff + IW'(1);
            if (scan_last) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.status = stat;
         unique case (stat)
            wllp_pkg::STAT_NONE: begin
               rsp_data_in.chosen_index  = '0;
               rsp_data_in.in_flight_now = '0;
               rsp_data_in.handled_now   = '0;
            end
            wllp_pkg::STAT_RANGE: begin
               rsp_data_in.chosen_index  = tgt_ff;
               rsp_data_in.in_flight_now = '0;
               rsp_data_in.handled_now   = '0;
            end
            default: begin
               rsp_data_in.chosen_index  = tgt_ff;
               rsp_data_in.in_flight_now = if_wide[wllp_pkg::REPORT_W-1:0];
               rsp_data_in.handled_now   = new_hd;
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         have_best_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cfg_count_ff   <= '0;
         cfg_weights_ff <= '0;
      end else begin
         state_ff       <= state_in;
         have_best_ff   <= have_best_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_count_ff   <= cfg_count_in;
         cfg_weights_ff <= cfg_weights_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      ok_ff        <= ok_in;
      tgt_ff       <= tgt_in;
      scan_ff      <= scan_in;
      best_load_ff <= best_load_in;
      best_w_ff    <= best_w_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- src/wllp_checker.sv -----
// Port-level checks for the weighted least-load picker, bound to the top level.
// Depends on wllp_pkg and weighted_least_load_picker_core.
`default_nettype none

module wllp_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire wllp_pkg::wllp_rsp_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: an accepted item blocks the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted back to back");

   // no backends: everything else reads zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == wllp_pkg::STAT_NONE |->
         rsp_data.chosen_index == '0 && rsp_data.in_flight_now == '0 &&
         rsp_data.handled_now == '0)
      else $error("no-backend result carries data");

   // bad index: counters read zero
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == wllp_pkg::STAT_RANGE |->
         rsp_data.in_flight_now == '0 && rsp_data.handled_now == '0)
      else $error("out-of-range result carries counters");

   // underflow leaves the in-flight count at zero
   a_under_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == wllp_pkg::STAT_UNDER |->
         rsp_data.in_flight_now == '0)
      else $error("underflow with nonzero in-flight count");

endmodule

bind weighted_least_load_picker_core wllp_checker u_wllp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
